### hw/rtl/pvs_pkg.sv
package pvs_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned VarsDefault = 16;
  localparam int unsigned CapDefault  = 64;

  // Field widths fixed by the interface.
  localparam int unsigned SampleW = 24;
  localparam int unsigned SizeW   = 7;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_FIRST  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DIFF,
    S_SQ,
    S_ACC,
    S_SRD,
    S_SCMP,
    S_WB,
    S_OUT
  } state_e;

  // Running statistics of one variable.
  typedef struct packed {
    logic        [23:0] count;
    logic signed [48:0] sum;
    logic        [62:0] sum_sq;
    logic signed [23:0] minimum;
    logic signed [23:0] maximum;
    logic signed [23:0] origin;
    logic        [6:0]  set_size;
    logic               set_ovf;
  } stats_t;

  localparam stats_t StatsReset = '{
    count:    24'd0,
    sum:      49'sd0,
    sum_sq:   63'd0,
    minimum:  24'sh7FFFFF,
    maximum:  24'sh800000,
    origin:   24'sd0,
    set_size: 7'd0,
    set_ovf:  1'b0
  };

endpackage

### hw/rtl/pvs_stats_ram.sv
module pvs_stats_ram #(
  parameter int unsigned VARS = pvs_pkg::VarsDefault,
  parameter int unsigned VW   = (VARS > 1) ? $clog2(VARS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [VW-1:0]   rd_addr_i,
  output pvs_pkg::stats_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [VW-1:0]   wr_addr_i,
  input  pvs_pkg::stats_t wr_data_i
);

  pvs_pkg::stats_t mem [VARS];
  pvs_pkg::stats_t rd_q;
  logic [VARS-1:0] valid_q;
  logic            rd_valid_q;

  // Entries that were never written read as the reset record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Storage array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : pvs_pkg::StatsReset;

endmodule

### hw/rtl/pvs_set_ram.sv
module pvs_set_ram #(
  parameter int unsigned DEPTH = pvs_pkg::VarsDefault * pvs_pkg::CapDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [AW-1:0]                       rd_addr_i,
  output logic signed [pvs_pkg::SampleW-1:0]  rd_data_o,
  input  logic                                wr_en_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic signed [pvs_pkg::SampleW-1:0]  wr_data_i
);

  logic signed [pvs_pkg::SampleW-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

### hw/rtl/per_variable_summary_stats.sv
// After an accepted sample the sequencer runs LOAD, DIFF, SQ, ACC, WB and OUT (result
// strobe); a set update adds at most an SRD and SCMP pass per value held (at most CAP, 64
// by default) and a last SRD; skipped items do less. New items wait for idle; the
// sorted-set scan with its single-port read, compare and shift-by-one write sets the worst
// case. Reset clears the sequencer, the register and the per-variable valid bits at once,
// so every variable reads as cleared with no sweep. The receiver cannot stall results.
module per_variable_summary_stats #(
  parameter int unsigned VARS = pvs_pkg::VarsDefault,
  parameter int unsigned CAP  = pvs_pkg::CapDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op_i,
  input  logic [3:0]          var_index_i,
  input  logic signed [23:0]  sample_i,
  input  logic                is_missing_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [6:0]          cfg_data_i,
  output logic                done_o,
  output logic [23:0]         count_o,
  output logic signed [48:0]  shifted_sum_o,
  output logic [62:0]         shifted_sum_sq_o,
  output logic signed [23:0]  minimum_o,
  output logic signed [23:0]  maximum_o,
  output logic signed [23:0]  origin_o,
  output logic [6:0]          distinct_count_o,
  output logic                distinct_overflow_o
);

  localparam int unsigned VW    = (VARS > 1) ? $clog2(VARS) : 1;
  localparam int unsigned DEPTH = VARS * CAP;
  localparam int unsigned AW    = $clog2(DEPTH);

  pvs_pkg::state_e state_q, state_d;
  pvs_pkg::op_e    op_q, op_d;
  pvs_pkg::stats_t rec_q, rec_d, st_rd_data;

  logic [VW-1:0]            idx_q, idx_d;
  logic                     in_range_q, in_range_d;
  logic signed [23:0]       x_q, x_d;
  logic                     miss_q, miss_d;
  logic signed [24:0]       a_q, a_d;
  logic [24:0]              mag_q, mag_d;
  logic [47:0]              sq_q, sq_d;
  logic [6:0]               i_q, i_d;
  logic signed [23:0]       carry_q, carry_d;
  logic                     ins_q, ins_d;
  logic [AW-1:0]            base_q, base_d;
  logic [6:0]               limit_q;
  logic [6:0]               lim;

  logic                     st_rd_en, st_wr_en;
  logic                     set_rd_en, set_wr_en;
  logic [AW-1:0]            set_rd_addr, set_wr_addr;
  logic signed [23:0]       set_wr_data, set_rd_data;

  logic signed [49:0]       sum_ext;
  logic [49:0]              prod;
  logic [63:0]              sq_ext;

  // Configuration register; writes land only while the block is idle.
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  assign lim = (32'(limit_q) > CAP) ? 7'(CAP) : limit_q;

  pvs_stats_ram #(
    .VARS (VARS),
    .VW   (VW)
  ) u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (VW'(var_index_i)),
    .rd_data_o (st_rd_data),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (idx_q),
    .wr_data_i (rec_q)
  );

  pvs_set_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_set (
    .clk_i     (clk_i),
    .rd_en_i   (set_rd_en),
    .rd_addr_i (set_rd_addr),
    .rd_data_o (set_rd_data),
    .wr_en_i   (set_wr_en),
    .wr_addr_i (set_wr_addr),
    .wr_data_i (set_wr_data)
  );

  // Shared arithmetic terms.
  assign sum_ext = $signed({rec_q.sum[48], rec_q.sum}) + $signed({{25{a_q[24]}}, a_q});
  assign prod    = mag_q * mag_q;
  assign sq_ext  = {1'b0, rec_q.sum_sq} + 64'(sq_q);

  // Control and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pvs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    rec_q      <= rec_d;
    idx_q      <= idx_d;
    in_range_q <= in_range_d;
    x_q        <= x_d;
    miss_q     <= miss_d;
    a_q        <= a_d;
    mag_q      <= mag_d;
    sq_q       <= sq_d;
    i_q        <= i_d;
    carry_q    <= carry_d;
    ins_q      <= ins_d;
    base_q     <= base_d;
  end

  // Sequencer: next state, datapath steps and memory controls.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rec_d       = rec_q;
    idx_d       = idx_q;
    in_range_d  = in_range_q;
    x_d         = x_q;
    miss_d      = miss_q;
    a_d         = a_q;
    mag_d       = mag_q;
    sq_d        = sq_q;
    i_d         = i_q;
    carry_d     = carry_q;
    ins_d       = ins_q;
    base_d      = base_q;
    st_rd_en    = 1'b0;
    st_wr_en    = 1'b0;
    set_rd_en   = 1'b0;
    set_rd_addr = base_q + AW'(i_q);
    set_wr_en   = 1'b0;
    set_wr_addr = base_q + AW'(i_q);
    set_wr_data = x_q;

    case (state_q)
      pvs_pkg::S_IDLE: begin
        if (start) begin
          st_rd_en   = 1'b1;
          op_d       = pvs_pkg::op_e'(op_i);
          idx_d      = VW'(var_index_i);
          in_range_d = 32'(var_index_i) < VARS;
          x_d        = sample_i;
          miss_d     = is_missing_i;
          state_d    = pvs_pkg::S_LOAD;
        end
      end

      pvs_pkg::S_LOAD: begin
        rec_d   = st_rd_data;
        base_d  = AW'(idx_q) * AW'(CAP);
        state_d = pvs_pkg::S_OUT;
        if (in_range_q) begin
          case (op_q)
            pvs_pkg::OP_CLEAR: begin
              rec_d   = pvs_pkg::StatsReset;
              state_d = pvs_pkg::S_WB;
            end
            pvs_pkg::OP_FIRST: begin
              rec_d.origin = miss_q ? 24'sd0 : x_q;
              state_d      = miss_q ? pvs_pkg::S_WB : pvs_pkg::S_DIFF;
            end
            pvs_pkg::OP_SAMPLE: begin
              state_d = miss_q ? pvs_pkg::S_OUT : pvs_pkg::S_DIFF;
            end
            default: begin
              state_d = pvs_pkg::S_OUT;
            end
          endcase
        end
      end

      // Offset from the origin and its magnitude.
      pvs_pkg::S_DIFF: begin
        a_d     = $signed({x_q[23], x_q}) - $signed({rec_q.origin[23], rec_q.origin});
        mag_d   = a_d[24] ? 25'(-a_d) : a_d;
        state_d = pvs_pkg::S_SQ;
      end

      // Square, saturating sum, count and extremes.
      pvs_pkg::S_SQ: begin
        sq_d = prod[47:0];
        if (sum_ext[49] != sum_ext[48]) begin
          rec_d.sum = sum_ext[49] ? {1'b1, 48'd0} : {1'b0, {48{1'b1}}};
        end else begin
          rec_d.sum = sum_ext[48:0];
        end
        if (rec_q.count != '1) begin
          rec_d.count = rec_q.count + 24'd1;
        end
        if (x_q < rec_q.minimum) begin
          rec_d.minimum = x_q;
        end
        if (x_q > rec_q.maximum) begin
          rec_d.maximum = x_q;
        end
        state_d = pvs_pkg::S_ACC;
      end

      // Saturating sum of squares, then the distinct set if it is live.
      pvs_pkg::S_ACC: begin
        rec_d.sum_sq = sq_ext[63] ? {63{1'b1}} : sq_ext[62:0];
        i_d          = '0;
        ins_d        = 1'b0;
        if (lim != '0 && !rec_q.set_ovf) begin
          state_d = pvs_pkg::S_SRD;
        end else begin
          state_d = pvs_pkg::S_WB;
        end
      end

      // Fetch the next stored value, or finish at the end of the set.
      pvs_pkg::S_SRD: begin
        if (i_q < rec_q.set_size) begin
          set_rd_en = 1'b1;
          state_d   = pvs_pkg::S_SCMP;
        end else begin
          state_d = pvs_pkg::S_WB;
          if (ins_q) begin
            set_wr_en      = 1'b1;
            set_wr_data    = carry_q;
            rec_d.set_size = rec_q.set_size + 7'd1;
          end else if (rec_q.set_size >= lim) begin
            rec_d.set_ovf = 1'b1;
          end else begin
            set_wr_en      = 1'b1;
            rec_d.set_size = rec_q.set_size + 7'd1;
          end
        end
      end

      // Compare, or shift the carried value up by one place.
      pvs_pkg::S_SCMP: begin
        state_d = pvs_pkg::S_SRD;
        i_d     = i_q + 7'd1;
        if (ins_q) begin
          set_wr_en   = 1'b1;
          set_wr_data = carry_q;
          carry_d     = set_rd_data;
        end else if (set_rd_data == x_q) begin
          state_d = pvs_pkg::S_WB;
        end else if (set_rd_data > x_q) begin
          if (rec_q.set_size >= lim) begin
            rec_d.set_ovf = 1'b1;
            state_d       = pvs_pkg::S_WB;
          end else begin
            set_wr_en = 1'b1;
            carry_d   = set_rd_data;
            ins_d     = 1'b1;
          end
        end
      end

      pvs_pkg::S_WB: begin
        st_wr_en = 1'b1;
        state_d  = pvs_pkg::S_OUT;
      end

      pvs_pkg::S_OUT: begin
        state_d = pvs_pkg::S_IDLE;
      end

      default: begin
        state_d = pvs_pkg::S_IDLE;
      end
    endcase
  end

  // Result ports; an index beyond the variables reports all zeros.
  assign busy                = state_q != pvs_pkg::S_IDLE;
  assign done_o              = state_q == pvs_pkg::S_OUT;
  assign count_o             = in_range_q ? rec_q.count    : '0;
  assign shifted_sum_o       = in_range_q ? rec_q.sum      : '0;
  assign shifted_sum_sq_o    = in_range_q ? rec_q.sum_sq   : '0;
  assign minimum_o           = in_range_q ? rec_q.minimum  : '0;
  assign maximum_o           = in_range_q ? rec_q.maximum  : '0;
  assign origin_o            = in_range_q ? rec_q.origin   : '0;
  assign distinct_count_o    = in_range_q ? rec_q.set_size : '0;
  assign distinct_overflow_o = in_range_q ? rec_q.set_ovf  : 1'b0;

  // An accepted item always makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not start the sequencer");

  // After a result the block is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block stayed busy after a result");

  // The distinct set never grows past the row capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 32'(distinct_count_o) <= CAP)
    else $error("distinct set grew beyond its row");

  // The set memory is written only during the set scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_wr_en |-> (state_q == pvs_pkg::S_SRD || state_q == pvs_pkg::S_SCMP))
    else $error("set memory written outside the scan");

endmodule

### tb/pvs_stats_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels of the summary statistics block,
// keeps its own copy of the per-variable state and checks every result in order.
module pvs_stats_checker #(
  parameter int unsigned VARS = pvs_pkg::VarsDefault,
  parameter int unsigned CAP  = pvs_pkg::CapDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         op_i,
  input  logic [3:0]         var_index_i,
  input  logic signed [23:0] sample_i,
  input  logic               is_missing_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i,
  input  logic               done_o,
  input  logic [23:0]        count_o,
  input  logic signed [48:0] shifted_sum_o,
  input  logic [62:0]        shifted_sum_sq_o,
  input  logic signed [23:0] minimum_o,
  input  logic signed [23:0] maximum_o,
  input  logic signed [23:0] origin_o,
  input  logic [6:0]         distinct_count_o,
  input  logic               distinct_overflow_o,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);

  localparam longint SumHi = 64'sh0000_FFFF_FFFF_FFFF;
  localparam longint SumLo = -SumHi - 1;
  localparam logic [63:0] SqHi = 64'h7FFF_FFFF_FFFF_FFFF;

  pvs_pkg::stats_t    var_stats [VARS];
  logic signed [23:0] set_vals [VARS][CAP];
  logic [6:0]         set_limit;
  pvs_pkg::stats_t    expected_q [$];

  assign pending_o = expected_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    errors_o++;
  endtask

  // Insert a value into the sorted distinct set of one variable.
  function automatic void insert_distinct(input int unsigned v, input logic signed [23:0] x);
    int unsigned lim;
    int unsigned size;
    int unsigned pos;
    lim  = (set_limit > CAP) ? CAP : set_limit;
    size = var_stats[v].set_size;
    pos  = 0;
    if (lim == 0 || var_stats[v].set_ovf) return;
    if (size > CAP) size = CAP;
    while (pos < size && set_vals[v][pos] < x) pos++;
    if (pos < size && set_vals[v][pos] == x) return;
    if (size >= lim) begin
      var_stats[v].set_ovf = 1'b1;
      return;
    end
    for (int unsigned h = size; h > pos; h--) set_vals[v][h] = set_vals[v][h-1];
    set_vals[v][pos] = x;
    var_stats[v].set_size = 7'(size + 1);
  endfunction

  // Fold one present sample into the running statistics.
  function automatic void accumulate(input int unsigned v, input logic signed [23:0] x);
    longint      delta;
    longint      total;
    logic [63:0] sq;
    logic [63:0] acc;
    delta = longint'(x) - longint'(var_stats[v].origin);
    total = longint'(var_stats[v].sum) + delta;
    sq    = 64'(delta * delta);
    acc   = 64'(var_stats[v].sum_sq);
    if (var_stats[v].count != 24'hFFFFFF) var_stats[v].count++;
    if (total > SumHi) total = SumHi;
    if (total < SumLo) total = SumLo;
    var_stats[v].sum = 49'(total);
    var_stats[v].sum_sq = (acc > SqHi - sq) ? 63'(SqHi) : 63'(acc + sq);
    if (x < var_stats[v].minimum) var_stats[v].minimum = x;
    if (x > var_stats[v].maximum) var_stats[v].maximum = x;
    insert_distinct(v, x);
  endfunction

  function automatic pvs_pkg::stats_t update_stats(input pvs_pkg::op_e op,
                                                   input logic [3:0] vi,
                                                   input logic signed [23:0] x,
                                                   input logic miss);
    int unsigned v;
    v = 32'(vi);
    if (v >= VARS) return '0;
    case (op)
      pvs_pkg::OP_CLEAR: var_stats[v] = pvs_pkg::StatsReset;
      pvs_pkg::OP_FIRST: begin
        var_stats[v].origin = miss ? 24'sd0 : x;
        if (!miss) accumulate(v, x);
      end
      pvs_pkg::OP_SAMPLE: if (!miss) accumulate(v, x);
      default: ;
    endcase
    return var_stats[v];
  endfunction

  // Compare each field of a result with the oldest expectation.
  task automatic check_result();
    pvs_pkg::stats_t want;
    if (expected_q.size() == 0) begin
      report("result with no item outstanding", 64'd1, 64'd0);
      return;
    end
    want = expected_q.pop_front();
    if (count_o != want.count) report("count", 64'(count_o), 64'(want.count));
    if (shifted_sum_o != want.sum) report("shifted_sum", 64'(shifted_sum_o), 64'(want.sum));
    if (shifted_sum_sq_o != want.sum_sq)
      report("shifted_sum_sq", 64'(shifted_sum_sq_o), 64'(want.sum_sq));
    if (minimum_o != want.minimum) report("minimum", 64'(minimum_o), 64'(want.minimum));
    if (maximum_o != want.maximum) report("maximum", 64'(maximum_o), 64'(want.maximum));
    if (origin_o != want.origin) report("origin", 64'(origin_o), 64'(want.origin));
    if (distinct_count_o != want.set_size)
      report("distinct_count", 64'(distinct_count_o), 64'(want.set_size));
    if (distinct_overflow_o != want.set_ovf)
      report("distinct_overflow", 64'(distinct_overflow_o), 64'(want.set_ovf));
  endtask

  initial begin
    errors_o  = 0;
    set_limit = '0;
    for (int v = 0; v < VARS; v++) var_stats[v] = pvs_pkg::StatsReset;
  end

  // Track register writes, check results and predict accepted items.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) set_limit = cfg_data_i;
      if (done_o) check_result();
      if (start && !busy)
        expected_q.push_back(update_stats(pvs_pkg::op_e'(op_i), var_index_i, sample_i,
                                          is_missing_i));
    end
  end

endmodule

### tb/tb_per_variable_summary_stats.sv
`timescale 1ns / 1ps

// Drives items and register writes into the summary statistics block and gives the verdict.
module tb_per_variable_summary_stats;

  localparam int unsigned StallLimit = 3000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         op_i = pvs_pkg::OP_NONE;
  logic [3:0]         var_index_i = '0;
  logic signed [23:0] sample_i = '0;
  logic               is_missing_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [6:0]         cfg_data_i = '0;
  logic               done_o;
  logic [23:0]        count_o;
  logic signed [48:0] shifted_sum_o;
  logic [62:0]        shifted_sum_sq_o;
  logic signed [23:0] minimum_o;
  logic signed [23:0] maximum_o;
  logic signed [23:0] origin_o;
  logic [6:0]         distinct_count_o;
  logic               distinct_overflow_o;
  int unsigned        pending;
  int unsigned        errors;
  int unsigned        stall_cycles = 0;
  bit                 no_gaps = 1'b0;

  always #5 clk_i = ~clk_i;

  per_variable_summary_stats i_dut (.*);

  pvs_stats_checker i_checker (.*, .pending_o(pending), .errors_o(errors));

  // End the run when no transfer of any kind has happened for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one item, with a random gap first, and return at the edge that takes it.
  task automatic send_item(input pvs_pkg::op_e op, input int unsigned v,
                           input logic signed [23:0] x, input bit miss);
    if (!no_gaps && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < 38) @(posedge clk_i);
    end
    op_i         <= op;
    var_index_i  <= 4'(v);
    sample_i     <= x;
    is_missing_i <= miss;
    start        <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
  endtask

  // Write the set capacity once every outstanding result has come back.
  task automatic write_limit(input logic [6:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    while (!no_gaps && $urandom_range(0, 99) < 38) @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random();
    int unsigned        r;
    pvs_pkg::op_e       op;
    int unsigned        v;
    logic signed [23:0] x;
    r  = $urandom_range(0, 99);
    op = (r < 4) ? pvs_pkg::OP_CLEAR : (r < 12) ? pvs_pkg::OP_FIRST :
         (r < 96) ? pvs_pkg::OP_SAMPLE : pvs_pkg::OP_NONE;
    v  = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    // A small pool makes duplicates and fills the distinct sets.
    x  = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 99)) - 24'sd50 : 24'($urandom);
    send_item(op, v, x, $urandom_range(0, 99) < 8);
  endtask

  initial begin
    logic [6:0] limits [7] = '{7'd127, 7'd0, 7'd64, 7'd7, 7'd1, 7'd64, 7'd33};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every operation, missing first row and clear, at reset capacity.
    send_item(pvs_pkg::OP_NONE, 0, 24'sd0, 1'b0);
    send_item(pvs_pkg::OP_FIRST, 0, 24'sh7FFFFF, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 0, 24'sh800000, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 0, 24'sd0, 1'b1);
    send_item(pvs_pkg::OP_FIRST, 1, 24'sd1234, 1'b1);
    send_item(pvs_pkg::OP_SAMPLE, 1, -24'sd1, 1'b0);
    send_item(pvs_pkg::OP_CLEAR, 0, 24'sh5A5A5A, 1'b1);
    send_item(pvs_pkg::OP_NONE, 0, 24'shFFFFFF, 1'b1);
    send_item(pvs_pkg::OP_FIRST, 15, 24'sh800000, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 15, 24'sh7FFFFF, 1'b0);

    // Directed: a tiny set that fills, sees a duplicate and then overflows.
    write_limit(7'd2);
    send_item(pvs_pkg::OP_FIRST, 2, 24'sd5, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 2, 24'sd3, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 2, 24'sd5, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 2, 24'sd9, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 2, -24'sd1, 1'b0);
    send_item(pvs_pkg::OP_FIRST, 3, -24'sd7, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 3, 24'sd7, 1'b0);

    // Directed: the capacity drops below the size already held.
    write_limit(7'd1);
    send_item(pvs_pkg::OP_SAMPLE, 3, -24'sd7, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 3, 24'sd8, 1'b0);
    send_item(pvs_pkg::OP_CLEAR, 2, 24'sd0, 1'b0);
    send_item(pvs_pkg::OP_SAMPLE, 2, 24'sd4, 1'b0);

    // Random phases at several capacities, one of them with no gaps at all.
    foreach (limits[p]) begin
      write_limit(limits[p]);
      no_gaps = (p == 2);
      repeat (100) send_random();
    end
    no_gaps = 1'b0;
    start <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/pvs_pkg.sv
hw/rtl/pvs_stats_ram.sv
hw/rtl/pvs_set_ram.sv
hw/rtl/per_variable_summary_stats.sv
tb/pvs_stats_checker.sv
tb/tb_per_variable_summary_stats.sv
